FILE: hdl/uesc_pkg.sv
package uesc_pkg;

    // Character codes
    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_LOWER_U   = 16'h0075;
    localparam logic [15:0] CH_UPPER_U   = 16'h0055;
    localparam logic [15:0] CH_DIGIT_0   = 16'h0030;
    localparam logic [15:0] CH_DIGIT_9   = 16'h0039;
    localparam logic [15:0] CH_UPPER_A   = 16'h0041;
    localparam logic [15:0] CH_UPPER_F   = 16'h0046;
    localparam logic [15:0] CH_LOWER_A   = 16'h0061;
    localparam logic [15:0] CH_LOWER_F   = 16'h0066;

    // Most results one input transaction can cause
    localparam int RES_MAX = 6;

    // Escape parser phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_ESC    = 6'b000010,
        PH_LETTER = 6'b000100,
        PH_DIG1   = 6'b001000,
        PH_DIG2   = 6'b010000,
        PH_DIG3   = 6'b100000
    } phase_t;

    // Result list handed from the decoder to the output stage
    typedef struct packed {
        logic [2:0]                 count;
        logic [RES_MAX-1:0][15:0]   units;
    } res_list_t;

    // Hex digit check: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [15:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F], [CH_LOWER_A:CH_LOWER_F]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

FILE: hdl/uesc_decode.sv
module uesc_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [15:0]         code_unit,
    input  logic                end_of_text,
    output uesc_pkg::res_list_t res
);
    import uesc_pkg::*;

    phase_t           phase_reg, phase_next;
    logic             cap_reg, cap_next;
    logic [2:0][15:0] dig_reg, dig_next;

    logic [4:0][15:0] flush;
    logic [2:0]       flush_n;
    logic [1:0]       dig_idx;
    phase_t           dig_phase;
    logic [4:0]       c_hex;
    logic [4:0]       h0, h1, h2;
    res_list_t        broken;
    phase_t           broken_phase;

    // Escape parser: next state and result list
    always_comb begin
        res        = '0;
        phase_next = phase_reg;
        cap_next   = cap_reg;
        dig_next   = dig_reg;

        c_hex = hex_digit(code_unit);
        h0    = hex_digit(dig_reg[0]);
        h1    = hex_digit(dig_reg[1]);
        h2    = hex_digit(dig_reg[2]);

        // buffered characters of a partial escape
        flush[0] = CH_BACKSLASH;
        flush[1] = cap_reg ? CH_UPPER_U : CH_LOWER_U;
        flush[2] = dig_reg[0];
        flush[3] = dig_reg[1];
        flush[4] = dig_reg[2];

        case (phase_reg)
            PH_LETTER: begin flush_n = 3'd2; dig_idx = 2'd0; dig_phase = PH_DIG1; end
            PH_DIG1:   begin flush_n = 3'd3; dig_idx = 2'd1; dig_phase = PH_DIG2; end
            PH_DIG2:   begin flush_n = 3'd4; dig_idx = 2'd2; dig_phase = PH_DIG3; end
            PH_DIG3:   begin flush_n = 3'd5; dig_idx = 2'd0; dig_phase = PH_IDLE; end
            default:   begin flush_n = 3'd0; dig_idx = 2'd0; dig_phase = PH_IDLE; end
        endcase

        // broken escape: buffered characters, then the breaking one as in idle
        for (int i = 0; i < RES_MAX - 1; i++) begin
            broken.units[i] = (3'(i) == flush_n) ? code_unit : flush[i];
        end
        broken.units[RES_MAX-1] = code_unit;
        if (code_unit == CH_BACKSLASH) begin
            broken.count = flush_n;
            broken_phase = PH_ESC;
        end else begin
            broken.count = flush_n + 3'd1;
            broken_phase = PH_IDLE;
        end

        if (end_of_text) begin
            case (phase_reg)
                PH_ESC: begin
                    res.units[0] = CH_BACKSLASH;
                    res.count    = 3'd1;
                end
                PH_LETTER, PH_DIG1, PH_DIG2, PH_DIG3: begin
                    res.units[4:0] = flush;
                    res.count      = flush_n;
                end
                default: ;
            endcase
            phase_next = PH_IDLE;
        end else begin
            case (phase_reg)
                PH_ESC: begin
                    if (code_unit == CH_LOWER_U || code_unit == CH_UPPER_U) begin
                        cap_next   = (code_unit == CH_UPPER_U);
                        phase_next = PH_LETTER;
                    end else begin
                        res.units[0] = CH_BACKSLASH;
                        res.units[1] = code_unit;
                        res.count    = 3'd2;
                        phase_next   = PH_IDLE;
                    end
                end
                PH_LETTER, PH_DIG1, PH_DIG2: begin
                    if (c_hex[4]) begin
                        dig_next[dig_idx] = code_unit;
                        phase_next        = dig_phase;
                    end else begin
                        res        = broken;
                        phase_next = broken_phase;
                    end
                end
                PH_DIG3: begin
                    if (c_hex[4]) begin
                        res.units[0] = {h0[3:0], h1[3:0], h2[3:0], c_hex[3:0]};
                        res.count    = 3'd1;
                        phase_next   = PH_IDLE;
                    end else begin
                        res        = broken;
                        phase_next = broken_phase;
                    end
                end
                default: begin
                    if (code_unit == CH_BACKSLASH) begin
                        phase_next = PH_ESC;
                    end else begin
                        res.units[0] = code_unit;
                        res.count    = 3'd1;
                        phase_next   = PH_IDLE;
                    end
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cap_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cap_reg   <= cap_next;
        end
    end

    // Digit buffer, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            dig_reg <= dig_next;
        end
    end

endmodule

FILE: hdl/uesc_emit.sv
module uesc_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  uesc_pkg::res_list_t res,
    output logic                busy_more,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast
);
    import uesc_pkg::*;

    logic [RES_MAX-1:0][15:0] units_reg, units_next;
    logic [2:0]               count_reg, count_next;
    logic                     pop;

    assign pop       = m_tvalid && m_tready;
    assign m_tvalid  = (count_reg != 3'd0);
    assign m_tdata   = units_reg[0];
    assign m_tlast   = (count_reg == 3'd1);
    // still busy after this cycle
    assign busy_more = (count_reg > 3'd1) || (m_tvalid && !m_tready);

    // Result queue: load a new list or shift one out
    always_comb begin
        units_next = units_reg;
        count_next = count_reg;
        if (load) begin
            units_next = res.units;
            count_next = res.count;
        end else if (pop) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                units_next[i] = units_reg[i+1];
            end
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        units_reg <= units_next;
    end

endmodule

FILE: hdl/unicode_escape_decoder_top.sv
// Backslash-u escape decoder. Each input transaction carries one 16-bit code unit
// in s_tdata, with s_tlast marking end of text (the code unit is then ignored and
// any pending partial escape is flushed). A backslash, u or U and four hex digits
// become one code unit; anything else passes through unchanged. An input
// transaction yields zero to six results on the master side, the last of them
// flagged by m_tlast. Input is taken every cycle while m_tready is high and each
// item yields at most one result; an item with several results holds the output
// register until they have left; the next input is taken in the cycle the last leaves.
module unicode_escape_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_unit
    output logic        m_tlast    // last_of_run
);
    import uesc_pkg::*;

    res_list_t res;
    logic      s_accept;
    logic      busy_more;

    assign s_tready = !busy_more;
    assign s_accept = s_tvalid && s_tready;

    // Parser
    uesc_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .code_unit   (s_tdata),
        .end_of_text (s_tlast),
        .res         (res)
    );

    // Output register / result queue
    uesc_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_accept && (res.count != 3'd0)),
        .res       (res),
        .busy_more (busy_more),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A transaction with results shows up on the output next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && res.count != 3'd0) |=> m_tvalid)
        else $error("accepted results not presented");

    // No new input while a run is only partly delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(m_tvalid && !m_tlast))
        else $error("input taken in the middle of a run");

    // A run is not cut short
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("run ended without last");

    // The decoder never produces more results than the queue holds
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (res.count <= 3'(RES_MAX)))
        else $error("result count out of range");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import uesc_pkg::*;

    localparam int TOTAL_ITEMS   = 310;
    localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction on either side
    localparam int LONG_HOLD     = 150;   // receiver hold-off for the backpressure test
    localparam int DRAIN_CYCLES  = 16;

    // One expected output transaction
    typedef struct {
        logic [15:0] unit;
        logic        last;
    } decoded_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;  // [15:0] code_unit
    logic        s_tlast = 1'b0;      // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [15:0] out_unit
    logic        m_tlast;             // last_of_run

    // Decoder state mirrored by the predictor
    phase_t      esc_phase;
    logic        esc_capital;
    logic [15:0] esc_digits [3];
    logic [15:0] item_units [$];
    decoded_t    expected_units [$];

    int          mismatch_count = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          src_gaps = 1'b0;
    bit          sink_stalls = 1'b0;
    bit          long_hold_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    unicode_escape_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int hex_nibble(input logic [15:0] c);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c - CH_DIGIT_0);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
        return -1;
    endfunction

    // Re-emit an escape that broke off: backslash, letter, digits so far
    function automatic void flush_escape();
        int held;
        case (esc_phase)
            PH_DIG1: held = 1;
            PH_DIG2: held = 2;
            PH_DIG3: held = 3;
            default: held = 0;
        endcase
        item_units.push_back(CH_BACKSLASH);
        item_units.push_back(esc_capital ? CH_UPPER_U : CH_LOWER_U);
        for (int i = 0; i < held; i++)
            item_units.push_back(esc_digits[i]);
    endfunction

    function automatic void take_plain(input logic [15:0] c);
        if (c == CH_BACKSLASH)
            esc_phase = PH_ESC;
        else
            item_units.push_back(c);
    endfunction

    function automatic void predict_decode(input logic [15:0] c, input logic eot);
        int nib;
        decoded_t r;
        item_units.delete();
        nib = hex_nibble(c);
        if (eot) begin
            if (esc_phase == PH_ESC)
                item_units.push_back(CH_BACKSLASH);
            else if (esc_phase != PH_IDLE)
                flush_escape();
            esc_phase = PH_IDLE;
        end else begin
            case (esc_phase)
                PH_ESC: begin
                    if (c == CH_LOWER_U || c == CH_UPPER_U) begin
                        esc_capital = (c == CH_UPPER_U);
                        esc_phase = PH_LETTER;
                    end else begin
                        item_units.push_back(CH_BACKSLASH);
                        item_units.push_back(c);
                        esc_phase = PH_IDLE;
                    end
                end
                PH_LETTER, PH_DIG1, PH_DIG2, PH_DIG3: begin
                    if (nib < 0) begin
                        flush_escape();
                        esc_phase = PH_IDLE;
                        take_plain(c);
                    end else begin
                        case (esc_phase)
                            PH_LETTER: begin
                                esc_digits[0] = c;
                                esc_phase = PH_DIG1;
                            end
                            PH_DIG1: begin
                                esc_digits[1] = c;
                                esc_phase = PH_DIG2;
                            end
                            PH_DIG2: begin
                                esc_digits[2] = c;
                                esc_phase = PH_DIG3;
                            end
                            default: begin
                                item_units.push_back({4'(hex_nibble(esc_digits[0])),
                                                      4'(hex_nibble(esc_digits[1])),
                                                      4'(hex_nibble(esc_digits[2])),
                                                      4'(nib)});
                                esc_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    esc_phase = PH_IDLE;
                    take_plain(c);
                end
            endcase
        end
        // Last result of this item carries the run marker
        for (int i = 0; i < item_units.size(); i++) begin
            r.unit = item_units[i];
            r.last = (i == item_units.size() - 1);
            expected_units.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // Compare each output transaction with the oldest expectation
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_units.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h last %b", m_tdata, m_tlast));
            end else begin
                want = expected_units.pop_front();
                if (m_tdata !== want.unit)
                    report_mismatch($sformatf("out_unit %h, expected %h", m_tdata, want.unit));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b (unit %h)",
                                              m_tlast, want.last, want.unit));
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("unicode_escape_decoder_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one
    function automatic int pick_gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Receiver: long hold-off on request, else random stalls
    always @(negedge aclk) begin
        if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left = pick_gap_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [15:0] c, input logic eot);
        int gap;
        gap = (src_gaps && $urandom_range(0, 2) == 0) ? pick_gap_len() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_decode(c, eot);
        items_sent++;
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item({8'h00, s[i]}, 1'b0);
    endtask

    function automatic logic [15:0] random_hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return CH_DIGIT_0 + 16'(v);
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 16'(v - 10);
    endfunction

    function automatic logic [15:0] random_letter();
        return $urandom_range(0, 1) ? CH_UPPER_U : CH_LOWER_U;
    endfunction

    // Code units weighted toward the ones the decoder looks at
    function automatic logic [15:0] random_code();
        logic [15:0] h;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5:       return random_hex_digit();
            6:          return CH_BACKSLASH;
            7:          return random_letter();
            8: begin
                case ($urandom_range(0, 5))
                    0: return CH_DIGIT_0 - 16'd1;
                    1: return CH_DIGIT_9 + 16'd1;
                    2: return CH_UPPER_A - 16'd1;
                    3: return CH_UPPER_F + 16'd1;
                    4: return CH_LOWER_A - 16'd1;
                    default: return CH_LOWER_F + 16'd1;
                endcase
            end
            default: begin
                // hex digit look-alike with a nonzero high byte
                h = random_hex_digit();
                return {8'($urandom_range(1, 255)), h[7:0]};
            end
        endcase
    endfunction

    function automatic logic [15:0] random_non_hex();
        logic [15:0] c;
        do c = random_code(); while (hex_nibble(c) >= 0);
        return c;
    endfunction

    // One random run: well-formed escapes most often, some broken ones and noise
    task automatic send_random_run();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                send_item(CH_BACKSLASH, 1'b0);
                send_item(random_letter(), 1'b0);
                repeat (4) send_item(random_hex_digit(), 1'b0);
            end
            4, 5: begin
                k = $urandom_range(0, 3);
                send_item(CH_BACKSLASH, 1'b0);
                send_item(random_letter(), 1'b0);
                repeat (k) send_item(random_hex_digit(), 1'b0);
                if ($urandom_range(0, 3) == 0)
                    send_item(16'($urandom), 1'b1);
                else
                    send_item(random_non_hex(), 1'b0);
            end
            6: begin
                send_item(CH_BACKSLASH, 1'b0);
                send_item(random_code(), $urandom_range(0, 4) == 0);
            end
            7: repeat ($urandom_range(1, 3)) send_item(16'($urandom), 1'b0);
            8: send_item(16'($urandom), 1'b1);
            default: repeat ($urandom_range(1, 4)) send_item(random_code(), 1'b0);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_plain_units();
        send_item(16'h0000, 1'b0);  // zero is an ordinary character
        send_item(16'hFFFF, 1'b0);
    endtask

    task automatic test_full_escape();
        send_chars("\\u0aF9");
    endtask

    task automatic test_broken_escape();
        // three digits then a backslash: five results, backslash opens a new escape
        send_chars("\\UfA0\\x");
        send_chars("\\uG");
    endtask

    task automatic test_passthrough();
        send_chars("\\\\");
    endtask

    task automatic test_end_of_text();
        send_chars("\\u12");
        send_item(16'h0000, 1'b1);
        send_chars("\\");
        send_item(16'hFFFF, 1'b1);
        send_item(16'hFFFF, 1'b1);  // idle: no result
    endtask

    // Receiver holds off while the sender keeps offering multi-result items
    task automatic test_backpressure();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        long_hold_req = 1'b1;
        send_chars("\\u123z\\\\ab\\UABCDq\\U9\\");
        send_item(16'h0000, 1'b1);
    endtask

    task automatic test_random_text();
        // back to back first, then with idling on both sides
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        while (items_sent < 110) send_random_run();
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        while (items_sent < TOTAL_ITEMS) send_random_run();
    endtask

    initial begin
        esc_phase = PH_IDLE;
        esc_capital = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_plain_units();
        test_full_escape();
        test_broken_escape();
        test_passthrough();
        test_end_of_text();
        test_backpressure();
        test_random_text();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_units.size() == 0)
            $display("unicode_escape_decoder_top test passed");
        else
            $display("unicode_escape_decoder_top test failed");
        $finish;
    end

endmodule
